### hw/rtl/assert_macros.svh
// Assertion macros shared by the battery level estimator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define BLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define BLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hw/rtl/ble_pkg.sv
// Types and constants of the battery level estimator.
`timescale 1ns / 1ps

package ble_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned SUM_W    = 16;
  localparam int unsigned DVD_W    = 24;
  localparam int unsigned VAL_W    = 27;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned IDX_W    = 3;

  localparam logic [CNT_W-1:0] MEAN_BITS  = 5'd16;
  localparam logic [CNT_W-1:0] MUL_BITS   = 5'd12;
  localparam logic [CNT_W-1:0] COMP_BITS  = 5'd24;
  localparam logic [CNT_W-1:0] LEVEL_BITS = 5'd19;

  localparam logic [SAMPLE_W-1:0] LOW_THR_RST   = 12'd2750;
  localparam logic [SAMPLE_W-1:0] HIGH_THR_RST  = 12'd2880;
  localparam logic [SAMPLE_W-1:0] SHUT_THR_RST  = 12'd2720;
  localparam logic [SAMPLE_W-1:0] LOW_LIMIT_RST = 12'd2680;
  localparam logic [SAMPLE_W-1:0] CHG_HIGH_RST  = 12'd3060;
  localparam logic [SAMPLE_W-1:0] CHG_OFS_RST   = 12'd160;

  localparam logic signed [LEVEL_W-1:0] LEVEL_FULL     = 8'sd100;
  localparam logic signed [LEVEL_W-1:0] LEVEL_EMPTY    = 8'sd0;
  localparam logic signed [LEVEL_W-1:0] LEVEL_SHUTDOWN = -8'sd1;

  typedef enum logic [IDX_W-1:0] {
    REG_LOW_THR   = 3'd0,
    REG_HIGH_THR  = 3'd1,
    REG_SHUT_THR  = 3'd2,
    REG_LOW_LIMIT = 3'd3,
    REG_CHG_HIGH  = 3'd4,
    REG_CHG_OFS   = 3'd5
  } ble_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MDIV,
    ST_COMP,
    ST_MUL,
    ST_CDIV,
    ST_CFIN,
    ST_CLASS,
    ST_LDIV,
    ST_LFIN,
    ST_DONE
  } ble_state_e;

endpackage

### hw/rtl/battery_level_estimator.sv
// Battery level estimator: sample window, bit-serial mean, charge compensation and level map.
//
//   Channel   Direction  Handshake                     Payload
//   s_axis    in         s_axis_tvalid_i/tready_o      sample in tdata, charging in tuser
//   m_axis    out        m_axis_tvalid_o/tready_i      level and mean_sample in tdata
//   cfg       in         cfg_valid_i/cfg_ready_o       register index and 12-bit value
//
// A request runs through the mean division, the charge compensation while the charger is
// active and the span is nonzero, and a division for a level on the linear segment.
// A single restoring divider that yields one quotient bit per cycle serves all divisions,
// together with a shift-and-add multiplier that takes one offset bit per cycle.
// Reset clears the sample window, the running sum and the registers to their defaults.
// A result waits in the output register, while the next sample is already accepted.
`timescale 1ns / 1ps

module battery_level_estimator
  import ble_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [11:0] sample
  input  logic        s_axis_tuser_i,   // [0] charging
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] level, [19:8] mean_sample
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

`include "assert_macros.svh"

  localparam int unsigned SlotW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam logic [SlotW-1:0] SlotLast = SlotW'(WINDOW_LEN - 1);

  ble_state_e state_q, state_d;

  logic [SAMPLE_W-1:0] low_thr_q, high_thr_q, shut_thr_q;
  logic [SAMPLE_W-1:0] low_limit_q, chg_high_q, chg_ofs_q;

  logic [SAMPLE_W-1:0] window_q [WINDOW_LEN];
  logic [SlotW-1:0]    slot_q;
  logic [SUM_W-1:0]    sum_q, sum_d;

  logic                charging_q;
  logic [DVD_W-1:0]    dvd_q;
  logic [SAMPLE_W-1:0] rem_q;
  logic [SAMPLE_W-1:0] dvs_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [SAMPLE_W-1:0] mcand_q;
  logic [SAMPLE_W-1:0] mpl_q;
  logic                neg_q;
  logic [SAMPLE_W-1:0] mean_q;
  logic signed [VAL_W-1:0]   val_q;
  logic signed [LEVEL_W-1:0] level_q;

  logic                      out_valid_q;
  logic signed [LEVEL_W-1:0] out_level_q;
  logic [SAMPLE_W-1:0]       out_mean_q;

  logic in_accept, in_ready, out_load, cnt_last;

  logic [SAMPLE_W:0]   rem_sh;
  logic                div_ge;
  logic [SAMPLE_W-1:0] div_rem_d;
  logic [DVD_W-1:0]    div_dvd_d;
  logic [DVD_W-1:0]    mul_acc_d;

  logic [SAMPLE_W-1:0]     mean_w;
  logic [SAMPLE_W:0]       diff_w, span_w, diff_neg_w, span_neg_w;
  logic [SAMPLE_W-1:0]     diff_mag, span_mag;
  logic                    comp_en;
  logic signed [VAL_W-1:0] low_ext, high_ext, shut_ext;
  logic                    class_low, class_high;
  logic [SAMPLE_W-1:0]     lin_x;
  logic [LEVEL_BITS-1:0]   lin_num;

  assign in_accept = s_axis_tvalid_i && in_ready;
  assign cnt_last  = (cnt_q == CNT_W'(1));
  assign sum_d     = sum_q - SUM_W'(window_q[slot_q]) + SUM_W'(s_axis_tdata_i[SAMPLE_W-1:0]);

  // Restoring division step: one quotient bit enters at the bottom of the dividend.
  assign rem_sh    = {rem_q, dvd_q[DVD_W-1]};
  assign div_ge    = (rem_sh >= {1'b0, dvs_q});
  assign div_rem_d = div_ge ? SAMPLE_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[SAMPLE_W-1:0];
  assign div_dvd_d = {dvd_q[DVD_W-2:0], div_ge};

  // Shift-and-add step, offset bits taken from the top.
  assign mul_acc_d = {dvd_q[DVD_W-2:0], 1'b0}
                   + (mpl_q[SAMPLE_W-1] ? {{(DVD_W-SAMPLE_W){1'b0}}, mcand_q} : '0);

  assign mean_w     = dvd_q[SAMPLE_W-1:0];
  assign diff_w     = {1'b0, mean_w} - {1'b0, low_limit_q};
  assign span_w     = {1'b0, chg_high_q} - {1'b0, low_limit_q};
  assign diff_neg_w = -diff_w;
  assign span_neg_w = -span_w;
  assign diff_mag   = diff_w[SAMPLE_W] ? diff_neg_w[SAMPLE_W-1:0] : diff_w[SAMPLE_W-1:0];
  assign span_mag   = span_w[SAMPLE_W] ? span_neg_w[SAMPLE_W-1:0] : span_w[SAMPLE_W-1:0];
  assign comp_en    = charging_q && (span_w != '0);

  assign low_ext    = $signed({{(VAL_W-SAMPLE_W){1'b0}}, low_thr_q});
  assign high_ext   = $signed({{(VAL_W-SAMPLE_W){1'b0}}, high_thr_q});
  assign shut_ext   = $signed({{(VAL_W-SAMPLE_W){1'b0}}, shut_thr_q});
  assign class_low  = (val_q <= low_ext);
  assign class_high = (val_q >= high_ext);
  assign lin_x      = SAMPLE_W'(val_q - low_ext);
  assign lin_num    = ({7'b0, lin_x} << 6) + ({7'b0, lin_x} << 5) + ({7'b0, lin_x} << 2);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_accept) state_d = ST_MDIV;
      ST_MDIV:  if (cnt_last) state_d = ST_COMP;
      ST_COMP:  state_d = comp_en ? ST_MUL : ST_CLASS;
      ST_MUL:   if (cnt_last) state_d = ST_CDIV;
      ST_CDIV:  if (cnt_last) state_d = ST_CFIN;
      ST_CFIN:  state_d = ST_CLASS;
      ST_CLASS: state_d = (class_low || class_high) ? ST_DONE : ST_LDIV;
      ST_LDIV:  if (cnt_last) state_d = ST_LFIN;
      ST_LFIN:  state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || m_axis_tready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_DONE: out_load = !out_valid_q || m_axis_tready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      slot_q      <= '0;
      sum_q       <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_accept) begin
        window_q[slot_q] <= s_axis_tdata_i[SAMPLE_W-1:0];
        sum_q            <= sum_d;
        slot_q           <= (slot_q == SlotLast) ? '0 : slot_q + SlotW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q   <= LOW_THR_RST;
      high_thr_q  <= HIGH_THR_RST;
      shut_thr_q  <= SHUT_THR_RST;
      low_limit_q <= LOW_LIMIT_RST;
      chg_high_q  <= CHG_HIGH_RST;
      chg_ofs_q   <= CHG_OFS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_LOW_THR:   low_thr_q   <= cfg_data_i;
        REG_HIGH_THR:  high_thr_q  <= cfg_data_i;
        REG_SHUT_THR:  shut_thr_q  <= cfg_data_i;
        REG_LOW_LIMIT: low_limit_q <= cfg_data_i;
        REG_CHG_HIGH:  chg_high_q  <= cfg_data_i;
        REG_CHG_OFS:   chg_ofs_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          charging_q <= s_axis_tuser_i;
          dvd_q      <= {sum_d, {(DVD_W-SUM_W){1'b0}}};
          rem_q      <= '0;
          dvs_q      <= SAMPLE_W'(WINDOW_LEN);
          cnt_q      <= MEAN_BITS;
        end
      end
      ST_MDIV, ST_CDIV, ST_LDIV: begin
        dvd_q <= div_dvd_d;
        rem_q <= div_rem_d;
        cnt_q <= cnt_q - CNT_W'(1);
      end
      ST_COMP: begin
        mean_q  <= mean_w;
        val_q   <= $signed({{(VAL_W-SAMPLE_W){1'b0}}, mean_w});
        mcand_q <= diff_mag;
        mpl_q   <= chg_ofs_q;
        dvs_q   <= span_mag;
        neg_q   <= diff_w[SAMPLE_W] ^ span_w[SAMPLE_W];
        dvd_q   <= '0;
        cnt_q   <= MUL_BITS;
      end
      ST_MUL: begin
        dvd_q <= mul_acc_d;
        mpl_q <= {mpl_q[SAMPLE_W-2:0], 1'b0};
        rem_q <= '0;
        cnt_q <= cnt_last ? COMP_BITS : cnt_q - CNT_W'(1);
      end
      ST_CFIN: begin
        if (neg_q) begin
          val_q <= $signed({{(VAL_W-SAMPLE_W){1'b0}}, mean_q})
                 + $signed({{(VAL_W-DVD_W){1'b0}}, dvd_q});
        end else begin
          val_q <= $signed({{(VAL_W-SAMPLE_W){1'b0}}, mean_q})
                 - $signed({{(VAL_W-DVD_W){1'b0}}, dvd_q});
        end
      end
      ST_CLASS: begin
        priority if (class_low) begin
          level_q <= (val_q < shut_ext) ? LEVEL_SHUTDOWN : LEVEL_EMPTY;
        end else if (class_high) begin
          level_q <= LEVEL_FULL;
        end else begin
          dvd_q <= {lin_num, {(DVD_W-LEVEL_BITS){1'b0}}};
          dvs_q <= high_thr_q - low_thr_q;
          rem_q <= '0;
          cnt_q <= LEVEL_BITS;
        end
      end
      ST_LFIN: begin
        level_q <= $signed(dvd_q[LEVEL_W-1:0]);
      end
      ST_DONE: begin
        if (out_load) begin
          out_level_q <= level_q;
          out_mean_q  <= mean_q;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready_o = in_ready;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_mean_q, out_level_q};

  `BLE_ASSERT(a_accept_starts_mean, in_accept |=> (state_q == ST_MDIV), "accept must start the mean division")
  `BLE_ASSERT(a_rem_below_dvs, ((state_q == ST_CDIV) || (state_q == ST_LDIV)) |-> (rem_q < dvs_q), "division remainder reached the divisor")
  `BLE_ASSERT(a_level_range, out_valid_q |-> ((out_level_q >= LEVEL_SHUTDOWN) && (out_level_q <= LEVEL_FULL)), "level out of range")
  `BLE_ASSERT(a_slot_range, slot_q <= SlotLast, "window slot out of range")
  `BLE_ASSERT(a_load_holds_valid, out_load |=> out_valid_q, "loaded result not presented")

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the battery level estimator.
`timescale 1ns / 1ps

module tb_top
  import ble_pkg::*;
();

  localparam int unsigned HIST_LEN = 10;
  localparam int unsigned HIST_SLOT_W = $clog2(HIST_LEN);
  localparam logic [HIST_SLOT_W-1:0] HIST_SLOT_LAST = HIST_SLOT_W'(HIST_LEN - 1);
  localparam logic [IDX_W-1:0] SPARE_IDX_LO = 3'd6;
  localparam logic [IDX_W-1:0] SPARE_IDX_HI = 3'd7;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic [SAMPLE_W-1:0]       mean;
  } gauge_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [11:0] cfg_data_i = '0;

  logic [SAMPLE_W-1:0]    hist_win [HIST_LEN];
  logic [SAMPLE_W-1:0]    reg_shadow [6];
  logic [SUM_W-1:0]       hist_sum;
  logic [HIST_SLOT_W-1:0] hist_slot;

  gauge_res_t pending_levels[$];
  int mismatch_cnt = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left = 0;
  int set_point = 2800;

  battery_level_estimator #(.WINDOW_LEN(HIST_LEN)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic void reset_gauge();
    for (int i = 0; i < HIST_LEN; i++) hist_win[i] = '0;
    hist_sum  = '0;
    hist_slot = '0;
    reg_shadow[REG_LOW_THR]   = LOW_THR_RST;
    reg_shadow[REG_HIGH_THR]  = HIGH_THR_RST;
    reg_shadow[REG_SHUT_THR]  = SHUT_THR_RST;
    reg_shadow[REG_LOW_LIMIT] = LOW_LIMIT_RST;
    reg_shadow[REG_CHG_HIGH]  = CHG_HIGH_RST;
    reg_shadow[REG_CHG_OFS]   = CHG_OFS_RST;
  endfunction

  function automatic gauge_res_t estimate_level(input logic [SAMPLE_W-1:0] smp,
                                                input logic chg);
    gauge_res_t res;
    longint avg, volts, span, lo, hi, lvl;
    hist_sum = hist_sum - SUM_W'(hist_win[hist_slot]);
    hist_win[hist_slot] = smp;
    hist_sum = hist_sum + SUM_W'(smp);
    hist_slot = (hist_slot == HIST_SLOT_LAST) ? '0 : hist_slot + HIST_SLOT_W'(1);
    avg   = longint'(hist_sum) / longint'(HIST_LEN);
    volts = avg;
    if (chg) begin
      span = longint'(reg_shadow[REG_CHG_HIGH]) - longint'(reg_shadow[REG_LOW_LIMIT]);
      if (span != 0)
        volts = avg - (longint'(reg_shadow[REG_CHG_OFS]) *
                       (avg - longint'(reg_shadow[REG_LOW_LIMIT]))) / span;
    end
    lo = longint'(reg_shadow[REG_LOW_THR]);
    hi = longint'(reg_shadow[REG_HIGH_THR]);
    if (volts <= lo) begin
      lvl = (volts < longint'(reg_shadow[REG_SHUT_THR])) ? longint'(LEVEL_SHUTDOWN)
                                                          : longint'(LEVEL_EMPTY);
    end else if (volts >= hi) begin
      lvl = longint'(LEVEL_FULL);
    end else if (hi - lo <= 0) begin
      lvl = longint'(LEVEL_EMPTY);
    end else begin
      lvl = (100 * (volts - lo)) / (hi - lo);
    end
    res.level = lvl[LEVEL_W-1:0];
    res.mean  = avg[SAMPLE_W-1:0];
    return res;
  endfunction

  function automatic logic [SAMPLE_W-1:0] clamp12(input int v);
    if (v < 0) return '0;
    if (v > 4095) return 12'hFFF;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_reg(input int nominal, input int spread);
    int r;
    r = int'($urandom_range(99));
    if (r < 8) return '0;
    if (r < 15) return 12'hFFF;
    return clamp12(nominal - spread + int'($urandom_range(2 * spread)));
  endfunction

  // Receiver: random idling, overridden by a counted hold-off.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready_i = 1'b0;
    end else begin
      m_axis_tready_i = (int'($urandom_range(99)) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    gauge_res_t want;
    logic signed [LEVEL_W-1:0] got_level;
    logic [SAMPLE_W-1:0] got_mean;
    got_level = m_axis_tdata_o[7:0];
    got_mean  = m_axis_tdata_o[19:8];
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected result, expected none, got level %0d mean %0d",
                 $time, got_level, got_mean);
        mismatch_cnt++;
      end else begin
        want = pending_levels.pop_front();
        if (got_level !== want.level) begin
          $display("%0t: level mismatch, expected %0d, got %0d",
                   $time, want.level, got_level);
          mismatch_cnt++;
        end
        if (got_mean !== want.mean) begin
          $display("%0t: mean_sample mismatch, expected %0d, got %0d",
                   $time, want.mean, got_mean);
          mismatch_cnt++;
        end
      end
    end
  end

  task automatic drain_results();
    while (pending_levels.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic chg);
    while (int'($urandom_range(99)) < send_idle_pct) @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {4'b0, smp};
    s_axis_tuser_i  = chg;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_levels.push_back(estimate_level(smp, chg));
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
    drain_results();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx <= REG_CHG_OFS) reg_shadow[idx] = val;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_defaults();
    write_reg(REG_LOW_THR, LOW_THR_RST);
    write_reg(REG_HIGH_THR, HIGH_THR_RST);
    write_reg(REG_SHUT_THR, SHUT_THR_RST);
    write_reg(REG_LOW_LIMIT, LOW_LIMIT_RST);
    write_reg(REG_CHG_HIGH, CHG_HIGH_RST);
    write_reg(REG_CHG_OFS, CHG_OFS_RST);
  endtask

  task automatic shuffle_settings();
    int base;
    base = int'($urandom_range(3995, 100));
    set_point = base;
    write_reg(REG_LOW_THR, pick_reg(base, 30));
    write_reg(REG_HIGH_THR, pick_reg(base + 150, 150));
    write_reg(REG_SHUT_THR, pick_reg(base - 60, 60));
    write_reg(REG_LOW_LIMIT, pick_reg(base - 200, 300));
    write_reg(REG_CHG_HIGH, pick_reg(base + 200, 400));
    write_reg(REG_CHG_OFS, pick_reg(150, 150));
    if ($urandom_range(9) == 0) write_reg(SPARE_IDX_HI, SAMPLE_W'($urandom_range(4095)));
  endtask

  task automatic push_near_set_point(input int count);
    int center;
    logic [SAMPLE_W-1:0] smp;
    center = set_point;
    repeat (count) begin
      if ($urandom_range(19) == 0) center = set_point - 300 + int'($urandom_range(700));
      if ($urandom_range(9) == 0) smp = SAMPLE_W'($urandom_range(4095));
      else smp = clamp12(center - 40 + int'($urandom_range(80)));
      push_sample(smp, 1'($urandom_range(1)));
    end
  endtask

  task automatic test_window_extremes();
    for (int i = 0; i < HIST_LEN; i++) push_sample(12'hFFF, i[0]);
    push_sample(12'h000, 1'b0);
    push_sample(12'h000, 1'b1);
  endtask

  task automatic test_charge_span();
    write_reg(REG_LOW_LIMIT, 12'd2000);
    write_reg(REG_CHG_HIGH, 12'd2000);
    push_sample(12'd2600, 1'b1);
    push_sample(12'd2900, 1'b1);
    write_reg(REG_CHG_HIGH, 12'd1500);
    push_sample(12'd2600, 1'b1);
    push_sample(12'd2700, 1'b1);
    write_reg(REG_LOW_LIMIT, 12'd0);
    write_reg(REG_CHG_HIGH, 12'd1);
    write_reg(REG_CHG_OFS, 12'hFFF);
    push_sample(12'hFFF, 1'b1);
    push_sample(12'hFFF, 1'b1);
    write_reg(REG_LOW_LIMIT, 12'd4094);
    write_reg(REG_CHG_HIGH, 12'hFFF);
    push_sample(12'd100, 1'b1);
    push_sample(12'd0, 1'b1);
    load_defaults();
  endtask

  task automatic test_threshold_order();
    write_reg(REG_LOW_THR, 12'd3000);
    write_reg(REG_HIGH_THR, 12'd2000);
    write_reg(REG_SHUT_THR, 12'd3500);
    push_sample(12'hFFF, 1'b0);
    write_reg(REG_SHUT_THR, 12'd0);
    write_reg(REG_LOW_THR, 12'd500);
    push_sample(12'hFFF, 1'b0);
    write_reg(REG_HIGH_THR, 12'd500);
    push_sample(12'd3000, 1'b0);
    write_reg(SPARE_IDX_LO, 12'hFFF);
    write_reg(SPARE_IDX_HI, 12'h000);
    push_sample(12'd2800, 1'b1);
    load_defaults();
  endtask

  task automatic run_traffic(input int n_items, input int tx_pct, input int rx_pct);
    int sent;
    int burst;
    send_idle_pct = tx_pct;
    recv_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      shuffle_settings();
      burst = int'($urandom_range(60, 20));
      push_near_set_point(burst);
      sent += burst;
    end
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    shuffle_settings();
    @(posedge clk_i);
    stall_left = 400;
    @(negedge clk_i);
    push_near_set_point(20);
    drain_results();
    recv_idle_pct = 54;
    push_near_set_point(20);
  endtask

  initial begin
    reset_gauge();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_window_extremes();
    test_charge_span();
    test_threshold_order();
    run_traffic(420, 36, 54);
    run_traffic(420, 54, 36);
    test_output_stall();
    run_traffic(420, 0, 0);
    drain_results();
    repeat (100) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_levels.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/ble_pkg.sv
hw/rtl/battery_level_estimator.sv
tb/sv/tb_top.sv
